@@ rtl/core/gfdd_pkg.sv @@
// ----------------------------------------------------------------------------
// gfdd_pkg
// Shared types and constants for the gamepad frame direction decoder.
// ----------------------------------------------------------------------------
package gfdd_pkg;

   localparam logic [7:0] FRAME_HEADER = 8'hC0;
   localparam logic [7:0] AXIS_CENTRE  = 8'h80;

   localparam int DIR_COUNT  = 8;
   localparam int DIR_BITS   = 3;
   localparam int MAG_BITS   = 8;
   localparam int SQ_BITS    = 16;
   localparam int PACK_BITS  = DIR_COUNT * MAG_BITS;

   // direction slots
   localparam logic [DIR_BITS-1:0] DIR_RIGHT = 3'd0;
   localparam logic [DIR_BITS-1:0] DIR_UP    = 3'd2;
   localparam logic [DIR_BITS-1:0] DIR_LEFT  = 3'd4;
   localparam logic [DIR_BITS-1:0] DIR_DOWN  = 3'd6;

   localparam logic [DIR_BITS-1:0] ROOT_TOP_BIT = 3'd7;
   localparam logic [1:0]          LAST_PAIR    = 2'd3;

   localparam logic REG_DEADZONE = 1'b0;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_LOAD,
      ENG_PAIR,
      ENG_SQX,
      ENG_SQY,
      ENG_ROOT,
      ENG_ROUND
   } eng_state_type;

   typedef struct packed {
      logic                start;
      logic                seen;
      logic [MAG_BITS-1:0] deadzone;
   } eng_ctl_type;

endpackage

@@ rtl/core/gamepad_frame_direction_decoder.sv @@
// ----------------------------------------------------------------------------
// gamepad_frame_direction_decoder
// Keeps controller frames with a valid header and reports buttons, centered
// stick coordinates and eight direction magnitudes per stick.
//
//   channel | dir | signals                         | payload
//   --------+-----+---------------------------------+------------------------
//   req     | in  | req_tvalid/tready/tdata[55:0]   | one frame
//   rsp     | out | rsp_tvalid/tready/tdata[183:0]  | decoded state
//   csr     | in  | csr_psel/penable/pwrite/paddr   | deadzone at 0x0
//
// The time to a result is set by the pair sequencer (one slot check per pair)
// and by the shared squarer, which squares both members, searches the root bit
// by bit and rounds it for each diagonal root. Reset is synchronous and active
// high. No new frame is taken until its result has moved into the output
// register; a stalled result holds there.
// ----------------------------------------------------------------------------
module gamepad_frame_direction_decoder
   import gfdd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // header, button_low, button_high, left_x_raw, left_y_raw,
   // right_x_raw, right_y_raw (8 bits each, from bit 0)
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,
   // buttons[13:0], left_x[21:14], left_y[30:22], right_x[38:31],
   // right_y[47:39], left_directions[111:48], right_directions[175:112],
   // frame_seen[176], zero pad [183:177]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [183:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic                 accept, load_out, eng_done;
   logic [MAG_BITS-1:0]  deadzone;
   eng_ctl_type          eng_ctl;
   logic [PACK_BITS-1:0] left_dirs, right_dirs;

   logic                 busy_ff, busy_in;
   logic                 start_ff, start_in;
   logic                 pending_ff, pending_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 seen_ff, seen_in;
   logic [13:0]          buttons_ff, buttons_in;
   logic [MAG_BITS-1:0]  axes_ff [4];
   logic [MAG_BITS-1:0]  axes_in [4];
   logic [183:0]         rsp_data_ff, rsp_data_in;

   logic [7:0]           lx, rx;
   logic [8:0]           ly, ry;

   gfdd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .deadzone    (deadzone)
   );

   assign eng_ctl.start    = start_ff;
   assign eng_ctl.seen     = seen_ff;
   assign eng_ctl.deadzone = deadzone;

   gfdd_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .ctl              (eng_ctl),
      .left_x_raw       (axes_ff[0]),
      .left_y_raw       (axes_ff[1]),
      .right_x_raw      (axes_ff[2]),
      .right_y_raw      (axes_ff[3]),
      .done             (eng_done),
      .left_directions  (left_dirs),
      .right_directions (right_dirs)
   );

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid & req_tready;
   assign load_out   = pending_ff & (!rsp_valid_ff | rsp_tready);

   assign lx = seen_ff ? (axes_ff[0] ^ AXIS_CENTRE) : '0;
   assign ly = seen_ff ? ({1'b0, AXIS_CENTRE} - {1'b0, axes_ff[1]}) : '0;
   assign rx = seen_ff ? (axes_ff[2] ^ AXIS_CENTRE) : '0;
   assign ry = seen_ff ? ({1'b0, AXIS_CENTRE} - {1'b0, axes_ff[3]}) : '0;

   always_comb begin
      seen_in    = seen_ff;
      buttons_in = buttons_ff;
      axes_in    = axes_ff;
      if (accept && (req_tdata[7:0] == FRAME_HEADER)) begin
         seen_in    = 1'b1;
         buttons_in = {req_tdata[21:16], req_tdata[15:8]};
         axes_in[0] = req_tdata[31:24];
         axes_in[1] = req_tdata[39:32];
         axes_in[2] = req_tdata[47:40];
         axes_in[3] = req_tdata[55:48];
      end

      start_in = accept;

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (load_out) begin
         busy_in = 1'b0;
      end

      pending_in = pending_ff;
      if (eng_done) begin
         pending_in = 1'b1;
      end else if (load_out) begin
         pending_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in = rsp_data_ff;
      if (load_out) begin
         rsp_data_in = {7'd0, seen_ff, right_dirs, left_dirs, ry, rx, ly, lx, buttons_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= 1'b0;
         buttons_ff   <= '0;
         for (int k = 0; k < 4; k++) begin
            axes_ff[k] <= '0;
         end
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         buttons_ff   <= buttons_in;
         axes_ff      <= axes_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && !req_tready))
      else $error("frame transfer did not block the input");

   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> (busy_ff && !pending_ff))
      else $error("engine finished without an outstanding frame");

   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_ff |=> seen_ff)
      else $error("frame seen flag dropped");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(busy_ff))
      else $error("result shown without a frame in work");
`endif

endmodule

@@ rtl/core/gfdd_squarer.sv @@
// ----------------------------------------------------------------------------
// gfdd_squarer
// Shared 8-bit squaring unit used for the pair sums, the root search and the rounding.
// ----------------------------------------------------------------------------
module gfdd_squarer
   import gfdd_pkg::*;
(
   input  logic [MAG_BITS-1:0] operand,
   output logic [SQ_BITS-1:0]  square
);

   assign square = SQ_BITS'(operand) * SQ_BITS'(operand);

endmodule

@@ rtl/core/gfdd_csr.sv @@
// ----------------------------------------------------------------------------
// gfdd_csr
// Register port holding the deadzone setting.
// ----------------------------------------------------------------------------
module gfdd_csr
   import gfdd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output logic [MAG_BITS-1:0] deadzone
);

   logic [MAG_BITS-1:0] deadzone_ff;
   logic [MAG_BITS-1:0] deadzone_in;
   logic                wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == REG_DEADZONE);

   always_comb begin
      deadzone_in = deadzone_ff;
      if (wr_hit) begin
         deadzone_in = csr_pwdata[MAG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= '0;
      end else begin
         deadzone_ff <= deadzone_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_DEADZONE) begin
         csr_prdata = {{(32-MAG_BITS){1'b0}}, deadzone_ff};
      end
   end

   assign deadzone = deadzone_ff;

endmodule

@@ rtl/core/gfdd_engine.sv @@
// ----------------------------------------------------------------------------
// gfdd_engine
// Sequencer that builds the eight direction bytes of each stick, resolving
// the four adjacent pairs one after another on a rotating slot register and
// rounding diagonal roots with the shared squarer.
// ----------------------------------------------------------------------------
module gfdd_engine
   import gfdd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  eng_ctl_type          ctl,
   input  logic [MAG_BITS-1:0]  left_x_raw,
   input  logic [MAG_BITS-1:0]  left_y_raw,
   input  logic [MAG_BITS-1:0]  right_x_raw,
   input  logic [MAG_BITS-1:0]  right_y_raw,
   output logic                 done,
   output logic [PACK_BITS-1:0] left_directions,
   output logic [PACK_BITS-1:0] right_directions
);

   eng_state_type        state_ff, state_in;
   logic [MAG_BITS-1:0]  dir_ff [DIR_COUNT];
   logic [MAG_BITS-1:0]  dir_in [DIR_COUNT];
   logic [MAG_BITS-1:0]  dir_tmp [DIR_COUNT];
   logic [SQ_BITS-1:0]   sum_ff, sum_in;
   logic [MAG_BITS-1:0]  root_ff, root_in;
   logic [DIR_BITS-1:0]  bit_ff, bit_in;
   logic [1:0]           pair_ff, pair_in;
   logic                 stick_ff, stick_in;
   logic [PACK_BITS-1:0] left_ff, left_in;
   logic [PACK_BITS-1:0] right_ff, right_in;

   logic [MAG_BITS-1:0]  mul_a;
   logic [SQ_BITS-1:0]   product;
   logic [MAG_BITS-1:0]  x_val, y_val;
   logic [MAG_BITS-1:0]  xraw, yraw;
   logic [MAG_BITS-1:0]  trial;
   logic [MAG_BITS-1:0]  res0, res1, res2;
   logic [PACK_BITS-1:0] packed_dirs;
   logic                 both_idle, near_diag, rotate, round_up;

   gfdd_squarer u_squarer (
      .operand (mul_a),
      .square  (product)
   );

   assign x_val     = dir_ff[0];
   assign y_val     = dir_ff[2];
   assign xraw      = stick_ff ? right_x_raw : left_x_raw;
   assign yraw      = stick_ff ? right_y_raw : left_y_raw;
   assign trial     = root_ff | (MAG_BITS'(1) << bit_ff);
   assign both_idle = (x_val <= ctl.deadzone) && (y_val <= ctl.deadzone);
   assign near_diag = (x_val != '0) && (y_val != '0)
                      && ({1'b0, x_val} < {y_val, 1'b0})
                      && ({1'b0, y_val} < {x_val, 1'b0});
   assign round_up  = ({1'b0, product} + {{(SQ_BITS+1-MAG_BITS){1'b0}}, root_ff})
                      < {1'b0, sum_ff};

   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      sum_in   = sum_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      pair_in  = pair_ff;
      stick_in = stick_ff;
      left_in  = left_ff;
      right_in = right_ff;
      done     = 1'b0;
      mul_a    = x_val;
      rotate   = 1'b0;
      res0     = x_val;
      res1     = dir_ff[1];
      res2     = y_val;
      dir_tmp  = dir_ff;
      packed_dirs = '0;

      unique case (state_ff)
         ENG_IDLE: begin
            if (ctl.start) begin
               stick_in = 1'b0;
               state_in = ENG_LOAD;
            end
         end
         ENG_LOAD: begin
            for (int k = 0; k < DIR_COUNT; k++) begin
               dir_in[k] = '0;
            end
            if (ctl.seen) begin
               if (xraw > AXIS_CENTRE) begin
                  dir_in[DIR_RIGHT] = xraw - AXIS_CENTRE;
               end else if (xraw < AXIS_CENTRE) begin
                  dir_in[DIR_LEFT] = AXIS_CENTRE - xraw;
               end
               if (yraw > AXIS_CENTRE) begin
                  dir_in[DIR_DOWN] = yraw - AXIS_CENTRE;
               end else if (yraw < AXIS_CENTRE) begin
                  dir_in[DIR_UP] = AXIS_CENTRE - yraw;
               end
            end
            pair_in  = '0;
            state_in = ENG_PAIR;
         end
         ENG_PAIR: begin
            priority if (both_idle) begin
               res0   = (x_val <= y_val) ? '0 : x_val;
               res2   = (y_val <= x_val) ? '0 : y_val;
               res1   = '0;
               rotate = 1'b1;
            end else if (near_diag) begin
               state_in = ENG_SQX;
            end else begin
               res0   = (x_val < y_val) ? '0 : x_val;
               res2   = (y_val < x_val) ? '0 : y_val;
               res1   = '0;
               rotate = 1'b1;
            end
         end
         ENG_SQX: begin
            mul_a    = x_val;
            sum_in   = product;
            state_in = ENG_SQY;
         end
         ENG_SQY: begin
            mul_a    = y_val;
            sum_in   = sum_ff + product;
            root_in  = '0;
            bit_in   = ROOT_TOP_BIT;
            state_in = ENG_ROOT;
         end
         ENG_ROOT: begin
            mul_a = trial;
            if (product <= sum_ff) begin
               root_in = trial;
            end
            if (bit_ff == '0) begin
               state_in = ENG_ROUND;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ENG_ROUND: begin
            mul_a  = root_ff;
            res0   = '0;
            res2   = '0;
            res1   = round_up ? root_ff + 1'b1 : root_ff;
            rotate = 1'b1;
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase

      if (rotate) begin
         dir_tmp[0] = res0;
         dir_tmp[1] = res1;
         dir_tmp[2] = res2;
         // advance: the next pair moves into slots 0 and 2
         for (int k = 0; k < DIR_COUNT; k++) begin
            dir_in[k] = dir_tmp[DIR_BITS'(k + 2)];
         end
         for (int k = 0; k < DIR_COUNT; k++) begin
            packed_dirs[MAG_BITS*k +: MAG_BITS] = dir_in[k];
         end
         pair_in = pair_ff + 1'b1;
         if (pair_ff == LAST_PAIR) begin
            if (!stick_ff) begin
               left_in  = packed_dirs;
               stick_in = 1'b1;
               state_in = ENG_LOAD;
            end else begin
               right_in = packed_dirs;
               done     = 1'b1;
               state_in = ENG_IDLE;
            end
         end else begin
            state_in = ENG_PAIR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         pair_ff  <= '0;
         stick_ff <= 1'b0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pair_ff  <= pair_in;
         stick_ff <= stick_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff   <= dir_in;
      sum_ff   <= sum_in;
      root_ff  <= root_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign left_directions  = left_ff;
   assign right_directions = right_ff;

endmodule

@@ bench/gamepad_frame_direction_decoder_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gamepad_frame_direction_decoder_test
// Drives controller frames into the decoder over the request stream, predicts
// the decoded buttons, stick coordinates and direction bytes for each transfer,
// and compares every result transfer field by field. Runs directed corner
// frames, then random frames under several deadzone settings, with random
// idling on both streams, a long result stall and a drained pause.
// ----------------------------------------------------------------------------
module gamepad_frame_direction_decoder_test;
   import gfdd_pkg::*;

   localparam logic [DIR_BITS-1:0] DIR_UPRIGHT   = 3'd1;
   localparam logic [DIR_BITS-1:0] DIR_UPLEFT    = 3'd3;
   localparam logic [DIR_BITS-1:0] DIR_DOWNLEFT  = 3'd5;
   localparam logic [DIR_BITS-1:0] DIR_DOWNRIGHT = 3'd7;
   localparam int IDLE_PERCENT = 16;
   localparam int STALL_CYCLES = 400;

   typedef struct packed {
      logic [7:0] right_y_raw;
      logic [7:0] right_x_raw;
      logic [7:0] left_y_raw;
      logic [7:0] left_x_raw;
      logic [7:0] button_high;
      logic [7:0] button_low;
      logic [7:0] header;
   } frame_t;

   typedef struct packed {
      logic              frame_seen;
      logic [63:0]       right_directions;
      logic [63:0]       left_directions;
      logic signed [8:0] right_y;
      logic signed [7:0] right_x;
      logic signed [8:0] left_y;
      logic signed [7:0] left_x;
      logic [13:0]       buttons;
   } decoded_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // predictor state
   logic [7:0]  deadzone_now;
   logic [13:0] kept_buttons;
   logic [7:0]  kept_axes [4];
   logic        seen_now;

   decoded_t pending_reports [$];
   int       fail_count;
   bit       quiet;
   bit       stall_due;

   gamepad_frame_direction_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic logic [7:0] settle_pair(inout logic [7:0][7:0] dirs,
                                              input logic [DIR_BITS-1:0] ia,
                                              input logic [DIR_BITS-1:0] ib);
      int x;
      int y;
      int sq;
      int r;
      x = dirs[ia];
      y = dirs[ib];
      if (x <= deadzone_now && y <= deadzone_now) begin
         if (x == y) begin
            dirs[ia] = 8'd0;
            dirs[ib] = 8'd0;
         end else if (x > y) begin
            dirs[ib] = 8'd0;
         end else begin
            dirs[ia] = 8'd0;
         end
         return 8'd0;
      end
      if (x != 0 && y != 0 && x < 2 * y && y < 2 * x) begin
         sq = x * x + y * y;
         r = 0;
         while ((r + 1) * (r + 1) <= sq) r++;
         if (sq > r * r + r) r++;
         dirs[ia] = 8'd0;
         dirs[ib] = 8'd0;
         return 8'(r);
      end
      if (x < y) dirs[ia] = 8'd0;
      else if (y < x) dirs[ib] = 8'd0;
      return 8'd0;
   endfunction

   function automatic logic [63:0] stick_directions(input logic [7:0] xraw,
                                                    input logic [7:0] yraw);
      logic [7:0][7:0] dirs;
      logic [7:0]      diag;
      dirs = '0;
      if (seen_now) begin
         if (xraw > AXIS_CENTRE) dirs[DIR_RIGHT] = xraw - AXIS_CENTRE;
         else if (xraw < AXIS_CENTRE) dirs[DIR_LEFT] = AXIS_CENTRE - xraw;
         if (yraw > AXIS_CENTRE) dirs[DIR_DOWN] = yraw - AXIS_CENTRE;
         else if (yraw < AXIS_CENTRE) dirs[DIR_UP] = AXIS_CENTRE - yraw;
      end
      diag = settle_pair(dirs, DIR_RIGHT, DIR_UP);
      dirs[DIR_UPRIGHT] = diag;
      diag = settle_pair(dirs, DIR_UP, DIR_LEFT);
      dirs[DIR_UPLEFT] = diag;
      diag = settle_pair(dirs, DIR_LEFT, DIR_DOWN);
      dirs[DIR_DOWNLEFT] = diag;
      diag = settle_pair(dirs, DIR_DOWN, DIR_RIGHT);
      dirs[DIR_DOWNRIGHT] = diag;
      return dirs;
   endfunction

   function automatic decoded_t decode_frame(input frame_t f);
      decoded_t d;
      if (f.header == FRAME_HEADER) begin
         seen_now     = 1'b1;
         kept_buttons = {f.button_high[5:0], f.button_low};
         kept_axes[0] = f.left_x_raw;
         kept_axes[1] = f.left_y_raw;
         kept_axes[2] = f.right_x_raw;
         kept_axes[3] = f.right_y_raw;
      end
      d = '0;
      d.buttons = kept_buttons;
      if (seen_now) begin
         d.left_x  = kept_axes[0] - AXIS_CENTRE;
         d.left_y  = {1'b0, AXIS_CENTRE} - {1'b0, kept_axes[1]};
         d.right_x = kept_axes[2] - AXIS_CENTRE;
         d.right_y = {1'b0, AXIS_CENTRE} - {1'b0, kept_axes[3]};
      end
      d.left_directions  = stick_directions(kept_axes[0], kept_axes[1]);
      d.right_directions = stick_directions(kept_axes[2], kept_axes[3]);
      d.frame_seen       = seen_now;
      return d;
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      decoded_t got;
      decoded_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[176:0];
         if (pending_reports.size() == 0) begin
            $error("result transfer with none expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("buttons", want.buttons, got.buttons);
            check_field("left_x", want.left_x, got.left_x);
            check_field("left_y", want.left_y, got.left_y);
            check_field("right_x", want.right_x, got.right_x);
            check_field("right_y", want.right_y, got.right_y);
            check_field("left_directions", want.left_directions, got.left_directions);
            check_field("right_directions", want.right_directions,
                        got.right_directions);
            check_field("frame_seen", want.frame_seen, got.frame_seen);
         end
      end
   end

   // receiver: random stalls, or one long hold when requested
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_due) begin
            stall_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
         rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------
   // shared tasks
   // ------------------------------------------------------------------
   task automatic send_frame(input frame_t f);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_reports.push_back(decode_frame(f));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic write_deadzone(input logic [7:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(4 * REG_DEADZONE);
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      deadzone_now = value;
      @(posedge clock);
   endtask

   function automatic frame_t make_frame(input logic [7:0] header, bl, bh,
                                         lx, ly, rx, ry);
      frame_t f;
      f.header      = header;
      f.button_low  = bl;
      f.button_high = bh;
      f.left_x_raw  = lx;
      f.left_y_raw  = ly;
      f.right_x_raw = rx;
      f.right_y_raw = ry;
      return f;
   endfunction

   function automatic logic [7:0] axis_raw(input int offset);
      if (offset > 127) offset = 127;
      if (offset < -128) offset = -128;
      return 8'(128 + offset);
   endfunction

   // random stick position, biased toward deadzone edges and diagonals
   task automatic random_stick(output logic [7:0] xr, output logic [7:0] yr);
      int m;
      int n;
      int spread;
      int t;
      case ($urandom_range(3))
         0: begin
            xr = 8'($urandom);
            yr = 8'($urandom);
         end
         1: begin
            spread = (deadzone_now > 120) ? 128 : deadzone_now + 4;
            xr = axis_raw($urandom_range(2 * spread) - spread);
            yr = axis_raw($urandom_range(2 * spread) - spread);
         end
         2: begin
            m = $urandom_range(1, 127);
            n = $urandom_range(m / 2 + 1, (2 * m - 1 > 127) ? 127 : 2 * m - 1);
            if ($urandom_range(1)) m = -m;
            if ($urandom_range(1)) n = -n;
            xr = axis_raw(m);
            yr = axis_raw(n);
         end
         default: begin
            m = $urandom_range(1, 63);
            n = ($urandom_range(1)) ? 2 * m : 0;
            if ($urandom_range(1)) m = -m;
            if ($urandom_range(1)) n = -n;
            if ($urandom_range(1)) begin
               t = m;
               m = n;
               n = t;
            end
            xr = axis_raw(m);
            yr = axis_raw(n);
         end
      endcase
   endtask

   task automatic send_random_frame();
      frame_t f;
      f.header = ($urandom_range(99) < 80) ? FRAME_HEADER : 8'($urandom);
      f.button_low  = 8'($urandom);
      f.button_high = 8'($urandom);
      random_stick(f.left_x_raw, f.left_y_raw);
      random_stick(f.right_x_raw, f.right_y_raw);
      send_frame(f);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_before_first_frame();
      send_frame(make_frame(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
      send_frame(make_frame(8'hFF, 8'hA5, 8'h3C, 8'h10, 8'hF0, 8'h80, 8'h01));
      send_frame(make_frame(8'hC1, 8'h5A, 8'hC3, 8'hFF, 8'h00, 8'hFF, 8'h00));
      send_frame(make_frame(8'h40, 8'h01, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80));
   endtask

   task automatic test_extremes();
      write_deadzone(8'd0);
      send_frame(make_frame(FRAME_HEADER, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'hC0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_frame(make_frame(FRAME_HEADER, 8'hAA, 8'h15, 8'h80, 8'h80, 8'h80, 8'h80));
      send_frame(make_frame(FRAME_HEADER, 8'h55, 8'h2A, 8'h00, 8'hFF, 8'hFF, 8'h00));
      // rejected frame: hold previous state
      send_frame(make_frame(8'h80, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC));
      send_frame(make_frame(FRAME_HEADER, 8'h01, 8'h20, 8'h81, 8'h7F, 8'h7F, 8'h81));
   endtask

   task automatic test_pair_resolution();
      write_deadzone(8'd20);
      // inside deadzone, unequal then equal
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'h00, 8'd138, 8'd113, 8'd118, 8'd138));
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'h00, 8'd140, 8'd116, 8'd108, 8'd148));
      // near diagonal, exactly twice, one axis centered
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'h00, 8'd228, 8'd48, 8'd28, 8'd208));
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'h00, 8'd228, 8'd78, 8'd78, 8'd228));
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'h00, 8'd128, 8'd0, 8'd255, 8'd128));
      // one member inside deadzone, the other outside
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'h00, 8'd138, 8'd28, 8'd148, 8'd149));
      // largest root
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'h00, 8'd0, 8'd0, 8'd255, 8'd255));
      write_deadzone(8'd255);
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'h00, 8'd0, 8'd0, 8'd255, 8'd255));
      send_frame(make_frame(FRAME_HEADER, 8'h00, 8'h00, 8'd0, 8'd200, 8'd100, 8'd128));
   endtask

   task automatic test_random(input logic [7:0] dz, input int count);
      write_deadzone(dz);
      repeat (count) send_random_frame();
   endtask

   task automatic test_back_pressure();
      wait_drained();
      quiet = 1'b1;
      stall_due = 1'b1;
      repeat (40) send_random_frame();
      repeat (200) send_random_frame();
      quiet = 1'b0;
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      deadzone_now = 8'd0;
      kept_buttons = '0;
      kept_axes    = '{default: 8'd0};
      seen_now     = 1'b0;
      fail_count   = 0;
      quiet        = 1'b0;
      stall_due    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_before_first_frame();
      test_extremes();
      test_pair_resolution();
      test_random(8'd0, 300);
      test_random(8'd255, 150);
      test_back_pressure();
      test_random(8'd20, 300);
      test_random(8'($urandom_range(1, 254)), 250);
      test_random(8'($urandom_range(1, 64)), 250);
      test_random(8'd0, 100);

      wait_drained();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
